// File: src/rne_pkg.sv
// Shared types, constants and letter tables for the Roman numeral emitter.
// Used by rne_front, rne_queue, rne_back and roman_numeral_emitter.
// No dependencies.
package rne_pkg;

  localparam int VALUE_W       = 12;
  localparam int LETTER_W      = 7;
  localparam int DIGIT_W       = 4;
  localparam int NUM_DIGITS    = 4;
  localparam int QUEUE_DEPTH   = 2;

  // letter role inside one decimal place
  localparam logic [1:0] SEL_ONE  = 2'd0;
  localparam logic [1:0] SEL_FIVE = 2'd1;
  localparam logic [1:0] SEL_TEN  = 2'd2;

  // decimal places (front split order and back letter tables)
  localparam logic [1:0] POS_ONES  = 2'd0;
  localparam logic [1:0] POS_TENS  = 2'd1;
  localparam logic [1:0] POS_HUND  = 2'd2;
  localparam logic [1:0] POS_THOU  = 2'd3;

  localparam logic [LETTER_W-1:0] CASE_OFFSET = 7'd32;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               lower_case;
  } rne_item_t;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last;
  } rne_result_t;

  typedef struct packed {
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;  // [3] thousands .. [0] ones
    logic                               lower;
  } rne_entry_t;

  // k times the weight of the place being split: tens, hundreds or thousands
  function automatic logic [13:0] rne_threshold(input logic [1:0] step,
                                                input logic [3:0] k);
    logic [13:0] kk;
    logic [13:0] thr;
    kk = {10'd0, k};
    unique case (step)
      POS_HUND: thr = kk * 14'd1000;
      POS_TENS: thr = kk * 14'd100;
      POS_ONES: thr = kk * 14'd10;
      default:  thr = '0;
    endcase
    return thr;
  endfunction

  // number of letters a digit produces in its place
  function automatic logic [2:0] rne_digit_len(input logic [DIGIT_W-1:0] d,
                                               input logic thou);
    logic [2:0] len;
    if (thou) begin
      len = d[2:0];
    end else begin
      unique case (d)
        4'd1:    len = 3'd1;
        4'd2:    len = 3'd2;
        4'd3:    len = 3'd3;
        4'd4:    len = 3'd2;
        4'd5:    len = 3'd1;
        4'd6:    len = 3'd2;
        4'd7:    len = 3'd3;
        4'd8:    len = 3'd4;
        4'd9:    len = 3'd2;
        default: len = 3'd0;
      endcase
    end
    return len;
  endfunction

  function automatic logic [1:0] rne_letter_sel(input logic [DIGIT_W-1:0] d,
                                                input logic [1:0] idx,
                                                input logic thou);
    logic [1:0] sel;
    priority if (thou) begin
      sel = SEL_ONE;
    end else if (d == 4'd4) begin
      sel = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
    end else if (d == 4'd9) begin
      sel = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
    end else if (d >= 4'd5) begin
      sel = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
    end else begin
      sel = SEL_ONE;
    end
    return sel;
  endfunction

  // upper-case ASCII letter for a place and role
  function automatic logic [LETTER_W-1:0] rne_letter(input logic [1:0] pos,
                                                     input logic [1:0] sel);
    logic [LETTER_W-1:0] c;
    unique case ({pos, sel})
      {POS_ONES, SEL_ONE}:  c = 7'h49;  // I
      {POS_ONES, SEL_FIVE}: c = 7'h56;  // V
      {POS_ONES, SEL_TEN}:  c = 7'h58;  // X
      {POS_TENS, SEL_ONE}:  c = 7'h58;  // X
      {POS_TENS, SEL_FIVE}: c = 7'h4C;  // L
      {POS_TENS, SEL_TEN}:  c = 7'h43;  // C
      {POS_HUND, SEL_ONE}:  c = 7'h43;  // C
      {POS_HUND, SEL_FIVE}: c = 7'h44;  // D
      {POS_HUND, SEL_TEN}:  c = 7'h4D;  // M
      default:              c = 7'h4D;  // M
    endcase
    return c;
  endfunction

endpackage

// File: src/rne_front.sv
// Front end: accepts items, drops zero values and splits the value into
// decimal digits one place per cycle with a shared compare unit.
// Depends on rne_pkg.
module rne_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  rne_pkg::rne_item_t item,
  output logic               busy,
  output logic               push,
  output rne_pkg::rne_entry_t entry,
  input  logic               full
);
  import rne_pkg::*;

  localparam logic [1:0] F_IDLE  = 2'd0;
  localparam logic [1:0] F_SPLIT = 2'd1;
  localparam logic [1:0] F_PUSH  = 2'd2;

  logic [1:0]         state;
  logic [1:0]         step;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] rem_next;
  logic [8:0]         ge;
  logic [3:0]         cnt;
  logic [13:0]        rem_less;
  logic               accept;

  assign accept = start && (state == F_IDLE);
  assign busy   = (state != F_IDLE);
  assign push   = (state == F_PUSH) && !full;

  // digit of the current place = number of multiples of its weight not above rem
  always_comb begin
    for (int k = 1; k <= 9; k++) begin
      ge[k-1] = {2'b00, rem} >= rne_threshold(step, 4'(k));
    end
    cnt      = 4'($countones(ge));
    rem_less = {2'b00, rem} - rne_threshold(step, cnt);
    rem_next = rem_less[VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (item.value != '0)) begin
            state <= F_SPLIT;
          end
        end
        F_SPLIT: begin
          if (step == POS_ONES) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem         <= item.value;
      entry.lower <= item.lower_case;
      step        <= POS_HUND;
    end else if (state == F_SPLIT) begin
      rem                      <= rem_next;
      entry.digits[2'(step + 2'd1)] <= cnt;
      step                     <= step - 2'd1;
      if (step == POS_ONES) begin
        entry.digits[POS_ONES] <= rem_next[DIGIT_W-1:0];
      end
    end
  end

endmodule

// File: src/rne_queue.sv
// Short queue of split items between front and back ends.
// Depends on rne_pkg; DEPTH must be at least 2.
module rne_queue #(
  parameter int DEPTH = rne_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  rne_pkg::rne_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output rne_pkg::rne_entry_t pop_entry,
  output logic                empty
);
  import rne_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rne_entry_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
`endif

endmodule

// File: src/rne_back.sv
// Back end: walks the digits of one queued item and emits one letter per
// cycle, skipping empty places. Depends on rne_pkg.
module rne_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  rne_pkg::rne_entry_t entry,
  output logic                pop,
  output logic                valid,
  output rne_pkg::rne_result_t result
);
  import rne_pkg::*;

  logic                                 active;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   digits;
  logic                                 lower;
  logic [1:0]                           pos;
  logic [1:0]                           idx;

  logic [DIGIT_W-1:0]  d;
  logic                thou;
  logic [2:0]          len;
  logic                end_digit;
  logic [1:0]          next_pos;
  logic                found;
  logic [1:0]          top_pos;
  logic                last_letter;
  logic [LETTER_W-1:0] base;

  always_comb begin
    d         = digits[pos];
    thou      = (pos == POS_THOU);
    len       = rne_digit_len(d, thou);
    end_digit = ({1'b0, idx} == (len - 3'd1));
    base      = rne_letter(pos, rne_letter_sel(d, idx, thou));
    // highest nonzero place below the current one
    next_pos  = POS_ONES;
    found     = 1'b0;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      if ((2'(p) < pos) && (digits[p] != '0)) begin
        next_pos = 2'(p);
        found    = 1'b1;
      end
    end
    // highest nonzero place of the incoming item
    top_pos = POS_ONES;
    for (int p = 0; p < NUM_DIGITS; p++) begin
      if (entry.digits[p] != '0) begin
        top_pos = 2'(p);
      end
    end
    last_letter = end_digit && !found;
  end

  assign pop = !empty && (!active || last_letter);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      valid  <= 1'b0;
    end else begin
      valid <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (active && last_letter) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.letter <= lower ? base + CASE_OFFSET : base;
    result.last   <= last_letter;
    if (pop) begin
      digits <= entry.digits;
      lower  <= entry.lower;
      pos    <= top_pos;
      idx    <= 2'd0;
    end else if (active) begin
      if (end_digit) begin
        pos <= next_pos;
        idx <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_nonempty_place: assert property (@(posedge clk) disable iff (rst)
    active |-> (len != 3'd0))
    else $error("back end sits on an empty place");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> ({1'b0, idx} < len))
    else $error("letter index past end of digit");
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (valid && !result.last) |=> valid)
    else $error("gap inside a numeral");
`endif

endmodule

// File: src/roman_numeral_emitter.sv
// Top level of the Roman numeral emitter: front end, queue and back end.
// Depends on rne_pkg, rne_front, rne_queue and rne_back.
//
// Usage:
//   Input: an item (value, lower_case) is taken at a rising edge with start
//   high and busy low. busy is high after a nonzero item while the front end
//   splits it into digits (one place per cycle) and hands it to the queue;
//   it stays high longer only if the queue is full. A zero value is taken and
//   dropped at once: busy stays low and no letters come out.
//   Output: letters leave one per cycle on result, each marked by valid for
//   exactly one cycle, most significant first; result.last marks the final
//   letter. The receiver cannot stall the block.
//   Path to the first letter: split steps, queue push, back-end pop, valid
//   register. Throughput: one letter per cycle while the back end holds an
//   item (at most 15 letters); the front end takes a new item only after it
//   pushed the last (pacing short items); items wait in DEPTH slots between ends.
//   Reset: rst, synchronous, empties the queue and stops output; no item is
//   in flight afterwards.
module roman_numeral_emitter #(
  parameter int DEPTH = rne_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rne_pkg::rne_item_t   item,
  output logic                 busy,
  output logic                 valid,
  output rne_pkg::rne_result_t result
);
  import rne_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  rne_entry_t front_entry;
  rne_entry_t back_entry;

  rne_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .push  (q_push),
    .entry (front_entry),
    .full  (q_full)
  );

  rne_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (front_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (back_entry),
    .empty      (q_empty)
  );

  rne_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .entry  (back_entry),
    .pop    (q_pop),
    .valid  (valid),
    .result (result)
  );

endmodule

// File: verif/roman_numeral_emitter_test.sv
// Self-checking testbench for roman_numeral_emitter: random and corner numbers
// in, letters checked against a scoreboard that spells each numeral itself.
// Depends on rne_pkg and the roman_numeral_emitter RTL.
`timescale 1ns / 1ps

module roman_numeral_emitter_test;
  import rne_pkg::*;

  localparam int NUM_RULES    = 13;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 24;

  localparam int unsigned RULE_AMOUNT [NUM_RULES] =
    '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
  localparam byte RULE_FIRST [NUM_RULES] =
    '{"M", "C", "D", "C", "C", "X", "L", "X", "X", "I", "V", "I", "I"};
  // zero where the rule writes a single letter
  localparam byte RULE_SECOND [NUM_RULES] =
    '{8'd0, "M", 8'd0, "D", 8'd0, "C", 8'd0, "L", 8'd0, "X", 8'd0, "V", 8'd0};

  class numeral_scoreboard;
    rne_result_t pending_letters[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function void push_letter(byte c, logic lower);
      rne_result_t r;
      r.letter = lower ? LETTER_W'(c + 8'd32) : LETTER_W'(c);
      r.last   = 1'b0;
      pending_letters.insert(pending_letters.size(), r);
    endfunction

    // spell the numeral greedily and queue its letters
    function void note_item(rne_item_t it);
      int unsigned rest;
      int          depth_before;
      int          r;
      rest = it.value;
      depth_before = pending_letters.size();
      for (r = 0; r < NUM_RULES; r++) begin
        while (rest >= RULE_AMOUNT[r]) begin
          push_letter(RULE_FIRST[r], it.lower_case);
          if (RULE_SECOND[r] != 0) begin
            push_letter(RULE_SECOND[r], it.lower_case);
          end
          rest -= RULE_AMOUNT[r];
        end
      end
      if (pending_letters.size() > depth_before) begin
        pending_letters[$].last = 1'b1;
      end
    endfunction

    task check_letter(rne_result_t got);
      rne_result_t want;
      if (pending_letters.size() == 0) begin
        report($sformatf("letter 0x%02h with nothing pending", got.letter));
      end else begin
        want = pending_letters.pop_front();
        if (got.letter != want.letter) begin
          report($sformatf("letter 0x%02h, want 0x%02h", got.letter, want.letter));
        end
        if (got.last != want.last) begin
          report($sformatf("last %0b, want %0b on letter 0x%02h",
                           got.last, want.last, want.letter));
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  rne_item_t   item;
  logic        busy;
  logic        valid;
  rne_result_t result;

  numeral_scoreboard sb = new();
  int                cycle_count = 0;

  roman_numeral_emitter u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .valid  (valid),
    .result (result)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result ports are stable mid-cycle; the value seen here is the one taken
  // at the next rising edge
  always @(negedge clk) begin
    if (!rst && valid) begin
      sb.check_letter(result);
    end
  end

  // hold start until the item is taken; returns in the step of acceptance
  task automatic send_item(logic [VALUE_W-1:0] v, logic lc);
    start <= 1'b1;
    item  <= '{value: v, lower_case: lc};
    // busy low mid-cycle means the coming rising edge takes the item
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_item('{value: v, lower_case: lc});
  endtask

  task automatic idle_for(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_letters();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending_letters.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      return '0;
    end else if (roll < 15) begin
      return VALUE_W'($urandom_range(1, 20));
    end else if (roll < 22) begin
      return VALUE_W'($urandom_range(3800, 4095));
    end else begin
      return VALUE_W'($urandom_range(0, 4095));
    end
  endfunction

  initial begin
    int unsigned corner_values [12] =
      '{0, 1, 4, 9, 49, 99, 444, 999, 1994, 3888, 4000, 4095};
    int unsigned sent;
    int unsigned burst;
    logic [VALUE_W-1:0] v;

    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corner_values[i]) begin
      send_item(VALUE_W'(corner_values[i]), 1'b0);
      send_item(VALUE_W'(corner_values[i]), 1'b1);
    end
    drain_letters();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      // mostly short bursts, now and then a long run without gaps
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (burst) begin
        v = pick_value();
        send_item(v, 1'($urandom_range(0, 1)));
        if (v != 0) begin
          sent++;
        end
        if (sent == RANDOM_ITEMS / 2) begin
          drain_letters();
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        idle_for($urandom_range(1, 20));
      end
    end

    drain_letters();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_letters.size() != 0) begin
      sb.report($sformatf("%0d letters never arrived", sb.pending_letters.size()));
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/rne_pkg.sv
src/rne_front.sv
src/rne_queue.sv
src/rne_back.sv
src/roman_numeral_emitter.sv
verif/roman_numeral_emitter_test.sv
